### sv/assert_macros.svh
// Assertion macros used by the modulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("check failed");
`define CHK_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_ALWAYS(lbl, clk, rst, expr)
`define CHK_SAME(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### sv/ffsk_pkg.sv
// Constants and types of the FFSK tone modulator.
`default_nettype none
package ffsk_pkg;
  localparam int TABLE_ADDR_BITS = 16;
  localparam int MAX_SAMPLES = 64;
  localparam int CNT_W = $clog2(MAX_SAMPLES);

  localparam int STEP_W = 29;
  localparam int AMP_W = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 29;

  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE = 2'd1;

  localparam logic [STEP_W-1:0] STEP_RESET = 29'd107374182;
  localparam logic [AMP_W-1:0] AMP_RESET = 15'd16384;

  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [15:0] SIN_B = 16'd21167;
  localparam logic [15:0] SIN_C = 16'd2463;
  localparam logic [14:0] MAG_MAX = 15'd32767;
  localparam logic [31:0] ROUND_HALF = 32'd16384;

  typedef struct packed {
    logic        start;
    logic [15:0] z;
  } seq_req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] mag;
  } seq_stat_t;
endpackage
`default_nettype wire

### sv/ffsk_mul.sv
// Shared 16x16 unsigned multiplier with registered product.
`default_nettype none
module ffsk_mul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] a,
  input  wire logic [15:0] b,
  output logic      [31:0] prod
);
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end
endmodule
`default_nettype wire

### sv/ffsk_sine_seq.sv
// Sequencer that evaluates the scaled quarter-wave sine on the shared multiplier.
`default_nettype none
module ffsk_sine_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ffsk_pkg::seq_req_t   req,
  input  wire logic [ffsk_pkg::AMP_W-1:0] amplitude,
  output ffsk_pkg::seq_stat_t       stat
);
  import ffsk_pkg::*;

  localparam logic [2:0] SQ_IDLE = 3'd0;
  localparam logic [2:0] SQ_ZZ   = 3'd1;
  localparam logic [2:0] SQ_CZ   = 3'd2;
  localparam logic [2:0] SQ_PZ2  = 3'd3;
  localparam logic [2:0] SQ_PZ   = 3'd4;
  localparam logic [2:0] SQ_AMP  = 3'd5;
  localparam logic [2:0] SQ_DONE = 3'd6;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [15:0] z;
  logic [15:0] z2;
  logic        done;
  logic [14:0] mag;
  logic        mul_en;
  logic [15:0] op_a;
  logic [15:0] op_b;
  logic [31:0] prod;
  logic [15:0] prod_q15;
  logic [16:0] m_wide;
  logic [14:0] m_sat;
  logic [31:0] rounded;

  ffsk_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (op_a),
    .b    (op_b),
    .prod (prod)
  );

  assign prod_q15 = prod[30:15];
  assign m_wide = prod[31:15];
  assign m_sat = (m_wide > {2'b00, MAG_MAX}) ? MAG_MAX : m_wide[14:0];
  assign rounded = prod + ROUND_HALF;

  always_comb begin
    mul_en = 1'b1;
    op_a = '0;
    op_b = '0;
    state_next = state;
    unique case (state)
      SQ_IDLE: begin
        mul_en = 1'b0;
        if (req.start) begin
          state_next = SQ_ZZ;
        end
      end
      SQ_ZZ: begin
        op_a = z;
        op_b = z;
        state_next = SQ_CZ;
      end
      SQ_CZ: begin
        op_a = SIN_C;
        op_b = prod_q15;
        state_next = SQ_PZ2;
      end
      SQ_PZ2: begin
        op_a = SIN_B - prod_q15;
        op_b = z2;
        state_next = SQ_PZ;
      end
      SQ_PZ: begin
        op_a = SIN_A - prod_q15;
        op_b = z;
        state_next = SQ_AMP;
      end
      SQ_AMP: begin
        op_a = {1'b0, m_sat};
        op_b = {1'b0, amplitude};
        state_next = SQ_DONE;
      end
      SQ_DONE: begin
        mul_en = 1'b0;
        state_next = SQ_IDLE;
      end
      default: begin
        mul_en = 1'b0;
        state_next = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == SQ_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == SQ_IDLE && req.start) begin
      z <= req.z;
    end
    if (state == SQ_CZ) begin
      z2 <= prod_q15;
    end
    if (state == SQ_DONE) begin
      mag <= rounded[29:15];
    end
  end

  assign stat.done = done;
  assign stat.mag = mag;
endmodule
`default_nettype wire

### sv/ffsk_tone_modulator_core.sv
// Top level of the FFSK tone modulator: phase accumulator, bit control and handshakes.
//
//   channel | signals                          | direction
//   input   | in_valid, in_ready, tone_bit     | in
//   output  | out_valid, out_ready, sample_value, last_sample | out
//   config  | cfg_we, cfg_addr, cfg_data       | in
//
// Each sample runs through these steps in order: the phase is decoded, five products
// run on the shared multiplier, the magnitude is rounded and handed back, and the
// sample is held until its transfer. A bit has n samples; n is set by phase_step,
// at most 64.
// Synchronous reset clears phase, polarity and registers to their defaults.
// in_ready is high only while no bit is in progress.
`default_nettype none
`include "assert_macros.svh"
module ffsk_tone_modulator_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              tone_bit,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [15:0]                     sample_value,
  output logic                                   last_sample,
  input  wire logic                              cfg_we,
  input  wire logic [ffsk_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [ffsk_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ffsk_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]        state;
  logic [STEP_W-1:0] phase_step;
  logic [AMP_W-1:0]  amplitude;
  logic [31:0]       phase;
  logic              polarity;
  logic              bit_val;
  logic              neg;
  logic [CNT_W-1:0]  cnt;

  logic [15:0]       t;
  logic [16:0]       u;
  logic [15:0]       z;
  logic [32:0]       phase_sum;
  logic              is_last;
  logic [15:0]       mag_ext;
  seq_req_t          req;
  seq_stat_t         stat;

  ffsk_sine_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .amplitude (amplitude),
    .stat      (stat)
  );

  assign t = 16'(phase[31 -: TABLE_ADDR_BITS]) << (16 - TABLE_ADDR_BITS);
  assign u = bit_val ? {t, 1'b0} : ({1'b0, t} + {t, 1'b0});
  assign z = u[15] ? (16'h8000 - {1'b0, u[14:0]}) : {1'b0, u[14:0]};

  assign req.start = (state == ST_START);
  assign req.z = z;

  assign phase_sum = {1'b0, phase} + {4'd0, phase_step};
  assign is_last = phase_sum[32] || (cnt == CNT_W'(MAX_SAMPLES - 1));

  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign mag_ext = {1'b0, stat.mag};
  assign sample_value = neg ? -mag_ext : mag_ext;
  assign last_sample = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
      amplitude <= AMP_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == REG_PHASE_STEP) begin
        phase_step <= cfg_data[STEP_W-1:0];
      end else if (cfg_addr == REG_AMPLITUDE) begin
        amplitude <= cfg_data[AMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= '0;
      polarity <= 1'b0;
      cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cnt <= '0;
            state <= ST_START;
          end
        end
        ST_START: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (stat.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            phase <= phase_sum[31:0];
            if (is_last) begin
              if (!bit_val) begin
                polarity <= ~polarity;
              end
              state <= ST_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
              state <= ST_START;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      bit_val <= tone_bit;
    end
    if (state == ST_START) begin
      neg <= u[16] ^ polarity;
    end
  end

  `CHK_ALWAYS(a_no_overlap, clk, rst, !(in_ready && out_valid))
  `CHK_SAME(a_cap_last, clk, rst, out_valid && (cnt == CNT_W'(MAX_SAMPLES - 1)), last_sample)
  `CHK_NEXT(a_start_calc, clk, rst, state == ST_START, !stat.done && state == ST_CALC)
  `CHK_SAME(a_done_calc, clk, rst, stat.done, state == ST_CALC)
endmodule
`default_nettype wire

### test/ffsk_tone_modulator_checker.sv
`timescale 1ns / 100ps
// Checker for the FFSK tone modulator: predicts the samples of each bit and compares transfers.
module ffsk_tone_modulator_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             tone_bit,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [15:0]               sample_value,
  input  logic                             last_sample,
  input  logic                             cfg_we,
  input  logic [ffsk_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ffsk_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               samples_due,
  output int                               fail_count
);
  import ffsk_pkg::*;

  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } tone_sample_t;

  tone_sample_t      due_samples[$];
  logic [31:0]       phase_acc;
  logic              polarity;
  logic [STEP_W-1:0] step;
  logic [AMP_W-1:0]  amp;

  function automatic logic signed [15:0] tone_sample(logic [31:0] phase, logic bit_val,
                                                     logic pol, logic [AMP_W-1:0] gain);
    logic [16:0] t;
    logic [16:0] turn;
    logic [31:0] z;
    logic [31:0] z2;
    logic [31:0] poly;
    logic [31:0] m;
    logic [31:0] mag;
    logic [63:0] prod;
    logic        neg;
    t = {1'b0, phase[31:16]};
    turn = bit_val ? (t << 1) : (t * 17'd3);
    z = turn[15] ? 32'd32768 - 32'(turn[14:0]) : 32'(turn[14:0]);
    z2 = (z * z) >> 15;
    poly = 32'(SIN_B) - ((32'(SIN_C) * z2) >> 15);
    poly = 32'(SIN_A) - ((poly * z2) >> 15);
    prod = (64'(poly) * 64'(z)) >> 15;
    m = (prod > 64'(MAG_MAX)) ? 32'(MAG_MAX) : prod[31:0];
    mag = (m * 32'(gain) + ROUND_HALF) >> 15;
    neg = turn[16] ^ pol;
    return neg ? -mag[15:0] : mag[15:0];
  endfunction

  function automatic void queue_bit_samples(logic bit_val);
    logic [32:0]  nxt;
    logic [31:0]  phase;
    tone_sample_t s;
    int           n;
    logic         done;
    phase = phase_acc;
    n = 0;
    done = 1'b0;
    while (!done) begin
      s.value = tone_sample(phase, bit_val, polarity, amp);
      n++;
      nxt = {1'b0, phase} + 33'(step);
      phase = nxt[31:0];
      done = nxt[32] || (n >= MAX_SAMPLES);
      s.last = done;
      due_samples.push_back(s);
    end
    phase_acc = phase;
    if (!bit_val) polarity = ~polarity;
  endfunction

  always @(posedge clk) begin : track
    tone_sample_t want;
    if (rst) begin
      due_samples.delete();
      phase_acc = '0;
      polarity = 1'b0;
      step = STEP_RESET;
      amp = AMP_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PHASE_STEP: step = cfg_data[STEP_W-1:0];
          REG_AMPLITUDE:  amp = cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_samples.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected sample %0d last %0b", $time, sample_value, last_sample);
        end else begin
          want = due_samples.pop_front();
          if (sample_value !== want.value || last_sample !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                       $time, want.value, want.last, sample_value, last_sample);
          end
        end
      end
      if (in_valid && in_ready) queue_bit_samples(tone_bit);
    end
    samples_due <= due_samples.size();
  end
endmodule

### test/ffsk_tone_modulator_core_test.sv
`timescale 1ns / 100ps
// Testbench top for the FFSK tone modulator: drives bits, register writes and sample stalls.
module ffsk_tone_modulator_core_test;
  import ffsk_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam logic [STEP_W-1:0]     STEP_SLOWEST = 29'd67108864;
  localparam logic [STEP_W-1:0]     STEP_FASTEST = 29'd429496730;
  localparam logic [STEP_W-1:0]     STEP_MAX = '1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  tone_bit = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [15:0]    sample_value;
  logic                  last_sample;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    samples_due;
  int                    fail_count;
  int                    cycles = 0;
  logic                  steady = 1'b0;

  ffsk_tone_modulator_core u_dut (.*);

  ffsk_tone_modulator_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_bit(input logic bit_val);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tone_bit <= bit_val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (samples_due != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [STEP_W-1:0] step_val,
                           input logic [CFG_DATA_W-1:0] amp_word, input logic spare);
    cfg_we <= 1'b1;
    cfg_addr <= REG_PHASE_STEP;
    cfg_data <= CFG_DATA_W'(step_val);
    @(posedge clk);
    cfg_addr <= REG_AMPLITUDE;
    cfg_data <= amp_word;
    @(posedge clk);
    if (spare) begin
      cfg_addr <= $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
      cfg_data <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : sample_stalls
    int hold;
    int stall;
    @(posedge clk);
    forever begin
      hold = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      stall = idle_len();
      out_ready <= 1'b1;
      repeat (hold) @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int                sent;
    int                count;
    int                pick;
    logic [STEP_W-1:0] step_val;
    logic [AMP_W-1:0]  amp_val;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_bit(1'b1); send_bit(1'b0); send_bit(1'b0);
    send_bit(1'b1); send_bit(1'b1); send_bit(1'b0);
    settle();
    configure(STEP_MAX, CFG_DATA_W'(MAG_MAX), 1'b0);
    send_bit(1'b0); send_bit(1'b1); send_bit(1'b0); send_bit(1'b1);
    settle();
    // zero amplitude: negated zeros
    configure(STEP_MAX, '0, 1'b0);
    send_bit(1'b0); send_bit(1'b1); send_bit(1'b0);
    settle();
    // phase never wraps: bit cut at the sample cap
    configure('0, CFG_DATA_W'(1), 1'b0);
    send_bit(1'b0); send_bit(1'b1);
    settle();
    configure(STEP_SLOWEST - 1, CFG_DATA_W'(MAG_MAX), 1'b0);
    send_bit(1'b1); send_bit(1'b0);
    settle();
    configure(STEP_SLOWEST, CFG_DATA_W'(MAG_MAX), 1'b1);
    send_bit(1'b0); send_bit(1'b1);
    settle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0: step_val = $urandom_range(0, STEP_SLOWEST - 1);
        1: step_val = STEP_SLOWEST;
        2: step_val = STEP_FASTEST;
        3: step_val = STEP_MAX;
        default: step_val = $urandom_range(STEP_SLOWEST, STEP_FASTEST);
      endcase
      case ($urandom_range(0, 9))
        0: amp_val = '0;
        1: amp_val = MAG_MAX;
        default: amp_val = $urandom_range(0, MAG_MAX);
      endcase
      configure(step_val, {14'($urandom), amp_val}, $urandom_range(0, 3) == 0);
      steady = ($urandom_range(0, 3) == 0);
      count = (pick == 0) ? $urandom_range(3, 8) : $urandom_range(20, 50);
      repeat (count) send_bit($urandom_range(0, 1));
      sent += count;
      settle();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
